/* rtl/sdl_pkg.sv */
`default_nettype none

package sdl_pkg;

    // Fixed field widths.
    localparam int DATA_W       = 32;
    localparam int OP_W         = 4;
    localparam int STATUS_W     = 2;

    // Default store depth and the matching count width.
    localparam int CAPACITY_DEF = 16;
    localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);

    // Operation codes carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_SORTED     = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_POP_BACK   = 4'd4,
        OP_REMOVE     = 4'd5,
        OP_ITER_START = 4'd6,
        OP_ITER_STEP  = 4'd7,
        OP_CLEAR      = 4'd8
    } sdl_op_t;

    // Status codes reported with each result item.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } sdl_status_t;

    // Command broadcast to every cell.
    typedef struct packed {
        sdl_op_t op;
        logic    commit;
    } sdl_cell_ctrl_t;

    // Position flags of one cell relative to the count and the cursor.
    typedef struct packed {
        logic head;
        logic occ;
        logic at_count;
        logic at_last;
        logic sel_cur;
    } sdl_cell_pos_t;

endpackage

`default_nettype wire

/* rtl/sdl_req_if.sv */
`default_nettype none

interface sdl_req_if;

    logic                              valid;
    logic                              ready;
    logic [sdl_pkg::OP_W-1:0]          op;
    logic signed [sdl_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);

endinterface

`default_nettype wire

/* rtl/sdl_rsp_if.sv */
`default_nettype none

interface sdl_rsp_if #(
    parameter int CNT_W = sdl_pkg::CNT_W_DEF
);

    logic                                valid;
    logic                                ready;
    logic signed [sdl_pkg::DATA_W-1:0]   read_value;
    logic                                read_valid;
    logic [CNT_W-1:0]                    count;
    logic                                is_empty;
    logic signed [sdl_pkg::DATA_W-1:0]   first_value;
    logic signed [sdl_pkg::DATA_W-1:0]   last_value;
    logic [sdl_pkg::STATUS_W-1:0]        status;

    modport source (
        output valid, output read_value, output read_valid, output count,
        output is_empty, output first_value, output last_value, output status,
        input ready
    );
    modport sink (
        input valid, input read_value, input read_valid, input count,
        input is_empty, input first_value, input last_value, input status,
        output ready
    );

endinterface

`default_nettype wire

/* rtl/sorted_deque_list.sv */
// Ordered list of up to CAPACITY signed 32-bit values held in a row of
// cells, one entry per cell, with entry 0 at the front. In the cycle an
// item is accepted every cell compares its entry against the operand and
// the whole row shifts at once; once the output register is free, the
// result (count, front, back, read value and status) is gathered from the
// updated row into the output register. The combinational depth grows with
// CAPACITY because the insert/remove mark and the two read buses ripple
// through the cells. A new item is accepted in the cycle after the previous
// one finishes gathering, even while its result is still waiting.
`default_nettype none

module sorted_deque_list #(
    parameter int CAPACITY = sdl_pkg::CAPACITY_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    sdl_req_if.sink   req,
    sdl_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // List and cursor state.
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic [CNT_W-1:0]                    cur_pos_reg;
    logic [CNT_W-1:0]                    cur_pos_next;
    logic                                cur_live_reg;
    logic                                cur_live_next;

    // Pending result fields taken in the accept cycle.
    logic                                busy_reg;
    logic                                busy_next;
    logic signed [sdl_pkg::DATA_W-1:0]   pend_rd_reg;
    logic signed [sdl_pkg::DATA_W-1:0]   pend_rd_next;
    logic                                pend_rv_reg;
    logic                                pend_rv_next;
    sdl_pkg::sdl_status_t                pend_st_reg;
    sdl_pkg::sdl_status_t                pend_st_next;

    // Output register.
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [sdl_pkg::DATA_W-1:0]   out_rd_reg;
    logic                                out_rv_reg;
    logic [CNT_W-1:0]                    out_cnt_reg;
    logic                                out_empty_reg;
    logic signed [sdl_pkg::DATA_W-1:0]   out_first_reg;
    logic signed [sdl_pkg::DATA_W-1:0]   out_last_reg;
    sdl_pkg::sdl_status_t                out_st_reg;
    logic                                out_load;

    // Row wiring.
    logic signed [sdl_pkg::DATA_W-1:0]   cell_data [CAPACITY];
    logic                                mark      [CAPACITY+1];
    logic signed [sdl_pkg::DATA_W-1:0]   last_bus  [CAPACITY+1];
    logic signed [sdl_pkg::DATA_W-1:0]   cur_bus   [CAPACITY+1];

    logic                                accept;
    sdl_pkg::sdl_op_t                    op;
    logic                                full;
    logic                                found;
    logic                                commit;
    sdl_pkg::sdl_cell_ctrl_t             ctrl;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign op        = sdl_pkg::sdl_op_t'(req.op);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign found     = mark[CAPACITY];

    assign ctrl.op     = op;
    assign ctrl.commit = commit;

    assign mark[0]     = 1'b0;
    assign last_bus[0] = '0;
    assign cur_bus[0]  = '0;

    // Row of cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sdl_pkg::sdl_cell_pos_t            pos;
        logic signed [sdl_pkg::DATA_W-1:0] left_data;
        logic signed [sdl_pkg::DATA_W-1:0] right_data;

        assign pos.head     = (i == 0);
        assign pos.occ      = (CNT_W'(i) < count_reg);
        assign pos.at_count = (count_reg == CNT_W'(i));
        assign pos.at_last  = (count_reg == CNT_W'(i + 1));
        assign pos.sel_cur  = (cur_pos_reg == CNT_W'(i));

        if (i == 0)
        begin : g_left_end
            assign left_data = req.value;
        end
        else
        begin : g_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_right_end
            assign right_data = cell_data[i];
        end
        else
        begin : g_right
            assign right_data = cell_data[i+1];
        end

        sdl_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .pos          (pos),
            .value        (req.value),
            .left_data    (left_data),
            .right_data   (right_data),
            .mark_in      (mark[i]),
            .last_bus_in  (last_bus[i]),
            .cur_bus_in   (cur_bus[i]),
            .mark_out     (mark[i+1]),
            .data         (cell_data[i]),
            .last_bus_out (last_bus[i+1]),
            .cur_bus_out  (cur_bus[i+1])
        );
    end

    // Operation control: count, cursor and pending result fields.
    always_comb
    begin
        commit        = 1'b0;
        count_next    = count_reg;
        cur_pos_next  = cur_pos_reg;
        cur_live_next = cur_live_reg;
        pend_rd_next  = pend_rd_reg;
        pend_rv_next  = pend_rv_reg;
        pend_st_next  = pend_st_reg;
        if (accept)
        begin
            pend_rd_next = '0;
            pend_rv_next = 1'b0;
            pend_st_next = sdl_pkg::ST_DONE;
            unique case (op)
                sdl_pkg::OP_PUSH_FRONT, sdl_pkg::OP_PUSH_BACK, sdl_pkg::OP_SORTED:
                begin
                    if (full)
                    begin
                        pend_st_next = sdl_pkg::ST_FULL;
                    end
                    else
                    begin
                        commit        = 1'b1;
                        count_next    = count_reg + 1'b1;
                        cur_live_next = 1'b0;
                    end
                end
                sdl_pkg::OP_POP_FRONT, sdl_pkg::OP_POP_BACK, sdl_pkg::OP_REMOVE:
                begin
                    if (found)
                    begin
                        commit        = 1'b1;
                        count_next    = count_reg - 1'b1;
                        cur_live_next = 1'b0;
                    end
                    else
                    begin
                        pend_st_next = sdl_pkg::ST_MISS;
                    end
                end
                sdl_pkg::OP_ITER_START:
                begin
                    cur_pos_next  = '0;
                    cur_live_next = (count_reg != '0);
                end
                sdl_pkg::OP_ITER_STEP:
                begin
                    if (cur_live_reg && (cur_pos_reg < count_reg))
                    begin
                        pend_rd_next  = cur_bus[CAPACITY];
                        pend_rv_next  = 1'b1;
                        cur_pos_next  = cur_pos_reg + 1'b1;
                        cur_live_next = ((cur_pos_reg + 1'b1) < count_reg);
                    end
                    else
                    begin
                        pend_rd_next  = '1;
                        cur_live_next = 1'b0;
                    end
                end
                sdl_pkg::OP_CLEAR:
                begin
                    count_next    = '0;
                    cur_live_next = 1'b0;
                end
                default:
                begin
                    commit = 1'b0;
                end
            endcase
        end
    end

    // Gather phase: load the output register once it is free.
    assign out_load = busy_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (accept)
            busy_next = 1'b1;
        else if (out_load)
            busy_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_pos_reg   <= '0;
            cur_live_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cur_pos_reg   <= cur_pos_next;
            cur_live_reg  <= cur_live_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_rd_reg <= pend_rd_next;
        pend_rv_reg <= pend_rv_next;
        pend_st_reg <= pend_st_next;
        if (out_load)
        begin
            out_rd_reg    <= pend_rd_reg;
            out_rv_reg    <= pend_rv_reg;
            out_st_reg    <= pend_st_reg;
            out_cnt_reg   <= count_reg;
            out_empty_reg <= (count_reg == '0);
            out_first_reg <= (count_reg == '0) ? '0 : cell_data[0];
            out_last_reg  <= last_bus[CAPACITY];
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_rd_reg;
    assign rsp.read_valid  = out_rv_reg;
    assign rsp.count       = out_cnt_reg;
    assign rsp.is_empty    = out_empty_reg;
    assign rsp.first_value = out_first_reg;
    assign rsp.last_value  = out_last_reg;
    assign rsp.status      = out_st_reg;

endmodule

`default_nettype wire

/* rtl/sdl_cell.sv */
`default_nettype none

// One list entry. The cell decides locally whether it is the insert or
// removal point, and passes a mark to its right neighbor so that every
// cell past that point shifts in the same cycle.
module sdl_cell (
    input  wire                                    clk,
    input  wire sdl_pkg::sdl_cell_ctrl_t           ctrl,
    input  wire sdl_pkg::sdl_cell_pos_t            pos,
    input  wire logic signed [sdl_pkg::DATA_W-1:0] value,
    input  wire logic signed [sdl_pkg::DATA_W-1:0] left_data,
    input  wire logic signed [sdl_pkg::DATA_W-1:0] right_data,
    input  wire                                    mark_in,
    input  wire logic signed [sdl_pkg::DATA_W-1:0] last_bus_in,
    input  wire logic signed [sdl_pkg::DATA_W-1:0] cur_bus_in,
    output logic                                   mark_out,
    output logic signed [sdl_pkg::DATA_W-1:0]      data,
    output logic signed [sdl_pkg::DATA_W-1:0]      last_bus_out,
    output logic signed [sdl_pkg::DATA_W-1:0]      cur_bus_out
);

    logic signed [sdl_pkg::DATA_W-1:0] data_reg;
    logic signed [sdl_pkg::DATA_W-1:0] data_next;
    logic                              hit;

    // Decide whether this cell is where the operation lands.
    always_comb
    begin
        unique case (ctrl.op)
            sdl_pkg::OP_PUSH_FRONT: hit = pos.head;
            sdl_pkg::OP_PUSH_BACK:  hit = pos.at_count;
            sdl_pkg::OP_SORTED:     hit = (pos.occ && (data_reg > value)) || pos.at_count;
            sdl_pkg::OP_POP_FRONT:  hit = pos.head && pos.occ;
            sdl_pkg::OP_POP_BACK:   hit = pos.at_last && pos.occ;
            sdl_pkg::OP_REMOVE:     hit = pos.occ && (data_reg == value);
            default:                hit = 1'b0;
        endcase
    end

    assign mark_out = mark_in || hit;

    // Inserts shift right past the landing point; removals shift left.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.commit)
        begin
            unique case (ctrl.op)
                sdl_pkg::OP_PUSH_FRONT, sdl_pkg::OP_PUSH_BACK, sdl_pkg::OP_SORTED:
                begin
                    if (mark_in)
                        data_next = left_data;
                    else if (hit)
                        data_next = value;
                end
                sdl_pkg::OP_POP_FRONT, sdl_pkg::OP_POP_BACK, sdl_pkg::OP_REMOVE:
                begin
                    if (mark_out)
                        data_next = right_data;
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    // Entry storage holds no reset value.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

    // Read buses ripple along the row; the selected cell drives its entry.
    assign last_bus_out = pos.at_last ? data_reg : last_bus_in;
    assign cur_bus_out  = pos.sel_cur ? data_reg : cur_bus_in;

endmodule

`default_nettype wire

/* rtl/sdl_checker.sv */
`default_nettype none

module sdl_checker #(
    parameter int CAPACITY = sdl_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input wire                                    clk,
    input wire                                    rst_n,
    input wire                                    rsp_valid,
    input wire                                    rsp_ready,
    input wire logic signed [sdl_pkg::DATA_W-1:0] read_value,
    input wire                                    read_valid,
    input wire [CNT_W-1:0]                        count,
    input wire                                    is_empty,
    input wire logic signed [sdl_pkg::DATA_W-1:0] first_value,
    input wire logic signed [sdl_pkg::DATA_W-1:0] last_value,
    input wire [sdl_pkg::STATUS_W-1:0]            status
);

    // The count never exceeds the store depth, and empty agrees with it.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (count <= CNT_W'(CAPACITY)) && (is_empty == (count == '0)))
        else $error("count out of range or empty flag mismatch");

    // An empty list reports zero at both ends.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> (first_value == '0) && (last_value == '0))
        else $error("empty list reports nonzero end values");

    // A rejected insert only happens on a full list.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == sdl_pkg::ST_FULL) |-> (count == CNT_W'(CAPACITY)))
        else $error("full status on a list that is not full");

    // A successful read never comes with a failure status.
    a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_valid |-> (status == sdl_pkg::ST_DONE) && !is_empty)
        else $error("read value flagged valid with bad status or empty list");

    // A stalled result item holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(count))
        else $error("result item changed while stalled");

endmodule

bind sorted_deque_list sdl_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_sdl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_value  (rsp.read_value),
    .read_valid  (rsp.read_valid),
    .count       (rsp.count),
    .is_empty    (rsp.is_empty),
    .first_value (rsp.first_value),
    .last_value  (rsp.last_value),
    .status      (rsp.status)
);

`default_nettype wire
